// File: hdl/phe_pkg.sv
`timescale 1ns / 1ps

package phe_pkg;

  // fixed field widths
  localparam int POS_W   = 32;
  localparam int QUAT_W  = 16;
  localparam int RAD_W   = 31;
  localparam int ANGLE_BITS = 16;
  localparam int CFG_IDX_W  = 2;

  // cordic sizing
  localparam int CORDIC_STAGES = 16;
  localparam int CW = 36;                    // x/y datapath width
  localparam int ZW = 34;                    // Q4.30 angle accumulator
  localparam int DW = 35;                    // bearing minus yaw
  localparam int ROUND_SH = 33 - ANGLE_BITS;

  // pipeline depth: diff, product, sum, prerotate, cordic, wrap, output
  localparam int NSTAGE = 6 + CORDIC_STAGES;
  localparam int CORDIC_FIRST = 3;

  localparam logic signed [DW-1:0] PI_Q30      = DW'(64'sd3373259426);
  localparam logic signed [DW-1:0] TWO_PI_Q30  = DW'(64'sd6746518852);
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = ZW'(64'sd1686629713);

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HOME_X        = 2'd0,
    CFG_HOME_Y        = 2'd1,
    CFG_ARRIVE_RADIUS = 2'd2,
    CFG_FORWARD_SPEED = 2'd3
  } cfg_idx_t;

  // atan(2^-i) in Q2.30, truncated
  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    logic [31:0] v;
    unique case (i)
      0:  v = 32'h3243F6A8;
      1:  v = 32'h1DAC6705;
      2:  v = 32'h0FADBAFC;
      3:  v = 32'h07F56EA6;
      4:  v = 32'h03FEAB76;
      5:  v = 32'h01FFD55B;
      6:  v = 32'h00FFFAAA;
      7:  v = 32'h007FFF55;
      8:  v = 32'h003FFFEA;
      9:  v = 32'h001FFFFD;
      10: v = 32'h000FFFFF;
      11: v = 32'h0007FFFF;
      12: v = 32'h0003FFFF;
      13: v = 32'h0001FFFF;
      14: v = 32'h0000FFFF;
      15: v = 32'h00007FFF;
      16: v = 32'h00003FFF;
      17: v = 32'h00001FFF;
      18: v = 32'h00000FFF;
      19: v = 32'h000007FF;
      20: v = 32'h000003FF;
      21: v = 32'h000001FF;
      22: v = 32'h000000FF;
      default: v = 32'h0000007F;
    endcase
    return $signed({{(ZW-32){1'b0}}, v});
  endfunction

endpackage

// File: hdl/phe_in_if.sv
`timescale 1ns / 1ps

interface phe_in_if;
  logic valid;
  logic ready;
  logic signed [phe_pkg::POS_W-1:0]  target_x;
  logic signed [phe_pkg::POS_W-1:0]  target_y;
  logic signed [phe_pkg::POS_W-1:0]  follower_x;
  logic signed [phe_pkg::POS_W-1:0]  follower_y;
  logic signed [phe_pkg::QUAT_W-1:0] follower_qx;
  logic signed [phe_pkg::QUAT_W-1:0] follower_qy;
  logic signed [phe_pkg::QUAT_W-1:0] follower_qz;
  logic signed [phe_pkg::QUAT_W-1:0] follower_qw;

  modport source (output valid, target_x, target_y, follower_x, follower_y,
                  follower_qx, follower_qy, follower_qz, follower_qw, input ready);
  modport sink (input valid, target_x, target_y, follower_x, follower_y,
                follower_qx, follower_qy, follower_qz, follower_qw, output ready);
endinterface

// File: hdl/phe_out_if.sv
`timescale 1ns / 1ps

interface phe_out_if;
  logic valid;
  logic ready;
  logic signed [phe_pkg::ANGLE_BITS-1:0] turn_rate;
  logic [phe_pkg::RAD_W-1:0]             linear_speed;
  logic                                  arrived;

  modport source (output valid, turn_rate, linear_speed, arrived, input ready);
  modport sink (input valid, turn_rate, linear_speed, arrived, output ready);
endinterface

// File: hdl/phe_cfg_if.sv
`timescale 1ns / 1ps

interface phe_cfg_if;
  logic valid;
  logic ready;
  logic [phe_pkg::CFG_IDX_W-1:0] index;
  logic [phe_pkg::POS_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/pursuit_heading_error.sv
`timescale 1ns / 1ps
// pipeline: 22 register stages between input word and result word
//   (3 setup, 1 fold + 16 cordic, wrap, round/output)
// throughput: one word per cycle; each stage advances when the next one frees
// rst_n (synchronous, active low) empties the pipeline and sets home to 0,
//   arrive_radius and forward_speed to 1.0

module pursuit_heading_error (
  input  logic    clk,
  input  logic    rst_n,
  phe_in_if.sink  in_if,
  phe_out_if.source out_if,
  phe_cfg_if.sink cfg_if
);

  localparam int N  = phe_pkg::NSTAGE;
  localparam int NS = phe_pkg::CORDIC_STAGES;
  localparam int CF = phe_pkg::CORDIC_FIRST;
  localparam int PW = phe_pkg::POS_W;
  localparam int CW = phe_pkg::CW;
  localparam int RW = phe_pkg::RAD_W;

  // configuration registers
  logic signed [PW-1:0] home_x_r;
  logic signed [PW-1:0] home_y_r;
  logic [RW-1:0]        radius_r;
  logic [RW-1:0]        speed_r;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      home_x_r <= '0;
      home_y_r <= '0;
      radius_r <= RW'(65536);
      speed_r  <= RW'(65536);
    end else if (cfg_if.valid) begin
      unique case (phe_pkg::cfg_idx_t'(cfg_if.index))
        phe_pkg::CFG_HOME_X:        home_x_r <= $signed(cfg_if.data);
        phe_pkg::CFG_HOME_Y:        home_y_r <= $signed(cfg_if.data);
        phe_pkg::CFG_ARRIVE_RADIUS: radius_r <= cfg_if.data[RW-1:0];
        phe_pkg::CFG_FORWARD_SPEED: speed_r  <= cfg_if.data[RW-1:0];
        default: ;
      endcase
    end
  end

  // stage valids and backward ready chain
  logic [N-1:0] v_r;
  logic [N:0]   rdy;

  always_comb begin
    rdy[N] = out_if.ready;
    for (int k = N - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign in_if.ready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_if.valid;
      end
      for (int k = 1; k < N; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // stage 0: differences
  logic signed [PW:0] dx0_r, dy0_r, hx0_r, hy0_r;
  logic signed [phe_pkg::QUAT_W-1:0] qx0_r, qy0_r, qz0_r, qw0_r;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      dx0_r <= (PW+1)'(in_if.target_x) - (PW+1)'(in_if.follower_x);
      dy0_r <= (PW+1)'(in_if.target_y) - (PW+1)'(in_if.follower_y);
      hx0_r <= (PW+1)'(in_if.follower_x) - (PW+1)'(home_x_r);
      hy0_r <= (PW+1)'(in_if.follower_y) - (PW+1)'(home_y_r);
      qx0_r <= in_if.follower_qx;
      qy0_r <= in_if.follower_qy;
      qz0_r <= in_if.follower_qz;
      qw0_r <= in_if.follower_qw;
    end
  end

  // stage 1: magnitudes and quaternion products
  logic signed [PW:0] dx1_r, dy1_r;
  logic [PW:0]        ax1_r, ay1_r;
  logic signed [2*phe_pkg::QUAT_W-1:0] wz1_r, xy1_r, yy1_r, zz1_r;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      dx1_r <= dx0_r;
      dy1_r <= dy0_r;
      ax1_r <= hx0_r[PW] ? $unsigned(-hx0_r) : $unsigned(hx0_r);
      ay1_r <= hy0_r[PW] ? $unsigned(-hy0_r) : $unsigned(hy0_r);
      wz1_r <= qw0_r * qz0_r;
      xy1_r <= qx0_r * qy0_r;
      yy1_r <= qy0_r * qy0_r;
      zz1_r <= qz0_r * qz0_r;
    end
  end

  // stage 2: squared distances and yaw vector
  logic [2*RW-1:0]      sqx2_r, sqy2_r, r22_r;
  logic                 box2_r;
  logic signed [CW-1:0] bx2_r, by2_r, yx2_r, yy2_r;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      sqx2_r <= ax1_r[RW-1:0] * ax1_r[RW-1:0];
      sqy2_r <= ay1_r[RW-1:0] * ay1_r[RW-1:0];
      r22_r  <= radius_r * radius_r;
      box2_r <= (ax1_r < (PW+1)'(radius_r)) && (ay1_r < (PW+1)'(radius_r));
      bx2_r  <= CW'(dx1_r);
      by2_r  <= CW'(dy1_r);
      yy2_r  <= (CW'(wz1_r) + CW'(xy1_r)) <<< 1;
      yx2_r  <= (CW'(64'sd1) <<< 28) - ((CW'(yy1_r) + CW'(zz1_r)) <<< 1);
    end
  end

  // arrival flag travels with the cordic stages
  logic arr_r [CF:N-2];

  always_ff @(posedge clk) begin
    if (rdy[CF]) begin
      arr_r[CF] <= box2_r && ((2*RW+1)'(sqx2_r) + (2*RW+1)'(sqy2_r) < (2*RW+1)'(r22_r));
    end
  end

  for (genvar k = CF + 1; k <= N - 2; k++) begin : g_arr
    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        arr_r[k] <= arr_r[k-1];
      end
    end
  end

  // bearing and yaw
  logic signed [phe_pkg::ZW-1:0] z_bear, z_yaw;

  phe_cordic u_bearing (
    .clk   (clk),
    .en    (rdy[CF +: NS+1]),
    .x_in  (bx2_r),
    .y_in  (by2_r),
    .z_out (z_bear)
  );

  phe_cordic u_yaw (
    .clk   (clk),
    .en    (rdy[CF +: NS+1]),
    .x_in  (yx2_r),
    .y_in  (yy2_r),
    .z_out (z_yaw)
  );

  // wrap difference into [-pi, pi]
  logic signed [phe_pkg::DW-1:0] diff, wrap_r;

  assign diff = phe_pkg::DW'(z_bear) - phe_pkg::DW'(z_yaw);

  always_ff @(posedge clk) begin
    if (rdy[N-2]) begin
      priority if (diff > phe_pkg::PI_Q30) begin
        wrap_r <= diff - phe_pkg::TWO_PI_Q30;
      end else if (diff < -phe_pkg::PI_Q30) begin
        wrap_r <= diff + phe_pkg::TWO_PI_Q30;
      end else begin
        wrap_r <= diff;
      end
    end
  end

  // round half up and drive result word
  logic signed [phe_pkg::DW-1:0] rnd;
  logic signed [phe_pkg::ANGLE_BITS-1:0] turn_r;
  logic [RW-1:0] lin_r;
  logic          arrived_r;

  assign rnd = (wrap_r + (phe_pkg::DW'(64'sd1) <<< (phe_pkg::ROUND_SH - 1)))
               >>> phe_pkg::ROUND_SH;

  always_ff @(posedge clk) begin
    if (rdy[N-1]) begin
      arrived_r <= arr_r[N-2];
      turn_r    <= arr_r[N-2] ? '0 : rnd[phe_pkg::ANGLE_BITS-1:0];
      lin_r     <= arr_r[N-2] ? '0 : speed_r;
    end
  end

  assign out_if.valid        = v_r[N-1];
  assign out_if.turn_rate    = turn_r;
  assign out_if.linear_speed = lin_r;
  assign out_if.arrived      = arrived_r;

  // an empty output register lets the whole chain take a word
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_if.valid |-> in_if.ready) else $error("input stalled with empty output");

  // arrived results carry zero commands
  a_arrived_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.arrived) |-> (out_if.turn_rate == '0 && out_if.linear_speed == '0))
    else $error("arrived word with nonzero command");

  // moving results carry the configured speed
  a_speed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && !out_if.arrived) |-> (out_if.linear_speed == speed_r))
    else $error("linear speed differs from forward speed");

endmodule

// File: hdl/phe_cordic.sv
`timescale 1ns / 1ps

module phe_cordic (
  input  logic                                  clk,
  input  logic [phe_pkg::CORDIC_STAGES:0]       en,
  input  logic signed [phe_pkg::CW-1:0]         x_in,
  input  logic signed [phe_pkg::CW-1:0]         y_in,
  output logic signed [phe_pkg::ZW-1:0]         z_out
);

  localparam int NS = phe_pkg::CORDIC_STAGES;

  logic signed [phe_pkg::CW-1:0] x_r [NS+1];
  logic signed [phe_pkg::CW-1:0] y_r [NS+1];
  logic signed [phe_pkg::ZW-1:0] z_r [NS+1];
  logic                          zero_r [NS+1];

  // quadrant fold for x < 0
  always_ff @(posedge clk) begin
    if (en[0]) begin
      zero_r[0] <= (x_in == '0) && (y_in == '0);
      if (x_in < 0) begin
        if (y_in >= 0) begin
          x_r[0] <= y_in;
          y_r[0] <= -x_in;
          z_r[0] <= phe_pkg::HALF_PI_Q30;
        end else begin
          x_r[0] <= -y_in;
          y_r[0] <= x_in;
          z_r[0] <= -phe_pkg::HALF_PI_Q30;
        end
      end else begin
        x_r[0] <= x_in;
        y_r[0] <= y_in;
        z_r[0] <= '0;
      end
    end
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < NS; i++) begin : g_stage
    logic signed [phe_pkg::CW-1:0] xs;
    logic signed [phe_pkg::CW-1:0] ys;
    assign xs = x_r[i] >>> i;
    assign ys = y_r[i] >>> i;
    always_ff @(posedge clk) begin
      if (en[i+1]) begin
        zero_r[i+1] <= zero_r[i];
        if (y_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] + ys;
          y_r[i+1] <= y_r[i] - xs;
          z_r[i+1] <= z_r[i] + phe_pkg::atan_q30(i);
        end else begin
          x_r[i+1] <= x_r[i] - ys;
          y_r[i+1] <= y_r[i] + xs;
          z_r[i+1] <= z_r[i] - phe_pkg::atan_q30(i);
        end
      end
    end
  end

  // coinciding points give zero angle
  assign z_out = zero_r[NS] ? '0 : z_r[NS];

endmodule

// File: tb/phe_tb_if.sv
`timescale 1ns / 1ps

// holds no logic of its own: the channel interfaces come with the block;
// this file keeps a small set of helper types shared by the test top
package phe_tb_pkg;

  typedef struct packed {
    logic signed [phe_pkg::POS_W-1:0]  target_x;
    logic signed [phe_pkg::POS_W-1:0]  target_y;
    logic signed [phe_pkg::POS_W-1:0]  follower_x;
    logic signed [phe_pkg::POS_W-1:0]  follower_y;
    logic signed [phe_pkg::QUAT_W-1:0] qx;
    logic signed [phe_pkg::QUAT_W-1:0] qy;
    logic signed [phe_pkg::QUAT_W-1:0] qz;
    logic signed [phe_pkg::QUAT_W-1:0] qw;
  } pose_word_t;

  typedef struct packed {
    logic signed [phe_pkg::ANGLE_BITS-1:0] turn_rate;
    logic [phe_pkg::RAD_W-1:0]             linear_speed;
    logic                                  arrived;
  } steer_word_t;
endpackage

// File: tb/pursuit_heading_error_test.sv
`timescale 1ns / 1ps

module pursuit_heading_error_test;

  localparam int LATENCY = 21;
  localparam longint CYCLE_LIMIT = 400000;

  localparam longint PI_L = 64'sd3373259426;
  localparam longint HALF_PI_L = 64'sd1686629713;

  logic clk;
  logic rst_n;

  phe_in_if  in_ch();
  phe_out_if out_ch();
  phe_cfg_if cfg_ch();

  pursuit_heading_error uut (
    .clk(clk), .rst_n(rst_n), .in_if(in_ch.sink), .out_if(out_ch.source),
    .cfg_if(cfg_ch.sink)
  );

  // predictor copy of the registers
  longint home_x_m, home_y_m;
  longint radius_m, speed_m;

  phe_tb_pkg::steer_word_t steer_q[$];
  int errors;
  longint cycles;
  bit hold_off;
  bit stall_on;

  // clock
  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("pursuit_heading_error_test: errors");
      $finish;
    end
  end

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    errors++;
  endtask

  function automatic longint shr_floor(input longint v, input int s);
    return v >>> s;
  endfunction

  // vectoring cordic angle, Q2.30
  function automatic longint cordic_angle(input longint y, input longint x);
    longint z, t, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = HALF_PI_L;
      end else begin
        t = x; x = -y; y = t; z = -HALF_PI_L;
      end
    end
    for (int i = 0; i < phe_pkg::CORDIC_STAGES && i < 24; i++) begin
      xs = shr_floor(x, i);
      ys = shr_floor(y, i);
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + longint'(phe_pkg::atan_q30(i));
      end else begin
        x = x - ys; y = y + xs; z = z - longint'(phe_pkg::atan_q30(i));
      end
    end
    return z;
  endfunction

  function automatic phe_tb_pkg::steer_word_t predict_steer(input phe_tb_pkg::pose_word_t p);
    phe_tb_pkg::steer_word_t r;
    longint ax, ay, bearing, yaw, diff, ang;
    longint qx, qy, qz, qw;
    bit near;
    ax = longint'(p.follower_x) - home_x_m;
    ay = longint'(p.follower_y) - home_y_m;
    if (ax < 0) ax = -ax;
    if (ay < 0) ay = -ay;
    near = 0;
    if (ax < radius_m && ay < radius_m)
      near = (ax * ax + ay * ay) < (radius_m * radius_m);
    if (near) begin
      r.turn_rate = '0; r.linear_speed = '0; r.arrived = 1'b1;
      return r;
    end
    qx = p.qx; qy = p.qy; qz = p.qz; qw = p.qw;
    bearing = cordic_angle(longint'(p.target_y) - longint'(p.follower_y),
                           longint'(p.target_x) - longint'(p.follower_x));
    yaw = cordic_angle(2 * (qw * qz + qx * qy), (64'sd1 << 28) - 2 * (qy * qy + qz * qz));
    diff = bearing - yaw;
    if (diff > PI_L) diff -= 2 * PI_L;
    if (diff < -PI_L) diff += 2 * PI_L;
    ang = (diff + (64'sd1 << (phe_pkg::ROUND_SH - 1))) >>> phe_pkg::ROUND_SH;
    r.turn_rate = ang[phe_pkg::ANGLE_BITS-1:0];
    r.linear_speed = speed_m[phe_pkg::RAD_W-1:0];
    r.arrived = 1'b0;
    return r;
  endfunction

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side: random stalls plus the long hold-off
  initial begin
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      int g;
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      g = stall_on ? gap_len() : 0;
      if (g > 0) begin
        out_ch.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      phe_tb_pkg::steer_word_t w;
      if (steer_q.size() == 0) begin
        report("unexpected result word", 1, 0);
      end else begin
        w = steer_q.pop_front();
        if (out_ch.turn_rate !== w.turn_rate)
          report("turn_rate", out_ch.turn_rate, w.turn_rate);
        if (out_ch.linear_speed !== w.linear_speed)
          report("linear_speed", out_ch.linear_speed, w.linear_speed);
        if (out_ch.arrived !== w.arrived)
          report("arrived", out_ch.arrived, w.arrived);
      end
    end
  end

  task automatic send_pose(input phe_tb_pkg::pose_word_t p, input bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.target_x <= p.target_x;
    in_ch.target_y <= p.target_y;
    in_ch.follower_x <= p.follower_x;
    in_ch.follower_y <= p.follower_y;
    in_ch.follower_qx <= p.qx;
    in_ch.follower_qy <= p.qy;
    in_ch.follower_qz <= p.qz;
    in_ch.follower_qw <= p.qw;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    steer_q.push_back(predict_steer(p));
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (steer_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(input phe_pkg::cfg_idx_t idx, input logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    case (idx)
      phe_pkg::CFG_HOME_X: home_x_m = longint'($signed(val));
      phe_pkg::CFG_HOME_Y: home_y_m = longint'($signed(val));
      phe_pkg::CFG_ARRIVE_RADIUS: radius_m = val[30:0];
      phe_pkg::CFG_FORWARD_SPEED: speed_m = val[30:0];
      default: ;
    endcase
  endtask

  function automatic logic signed [15:0] rand_q();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return 16'sd16384;
    if (k == 1) return -16'sd16384;
    if (k == 2) return 16'($urandom());
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic logic [31:0] rand_pos();
    int k;
    k = $urandom_range(0, 9);
    if (k < 2) return $urandom();
    if (k < 4) return 32'($signed($urandom_range(0, 131072)) - 65536);
    return 32'($signed($urandom_range(0, 32'h00400000)) - 32'sh00200000);
  endfunction

  function automatic phe_tb_pkg::pose_word_t rand_pose();
    phe_tb_pkg::pose_word_t p;
    p.target_x = rand_pos(); p.target_y = rand_pos();
    p.follower_x = rand_pos(); p.follower_y = rand_pos();
    case ($urandom_range(0, 5))
      0: p.follower_x = 32'(home_x_m + $signed($urandom_range(0, 2 * 65536)) - 65536);
      1: begin
        p.target_x = p.follower_x; p.target_y = p.follower_y;
      end
      default: ;
    endcase
    p.qx = rand_q(); p.qy = rand_q(); p.qz = rand_q(); p.qw = rand_q();
    return p;
  endfunction

  function automatic phe_tb_pkg::pose_word_t mk(input logic [31:0] tx, ty, fx, fy,
                                                input logic [15:0] qx, qy, qz, qw);
    phe_tb_pkg::pose_word_t p;
    p.target_x = tx; p.target_y = ty; p.follower_x = fx; p.follower_y = fy;
    p.qx = qx; p.qy = qy; p.qz = qz; p.qw = qw;
    return p;
  endfunction

  // extremes, coinciding positions, degenerate quaternion, arrival edge
  task automatic test_directed();
    send_pose(mk(0, 0, 0, 0, 0, 0, 0, 16384), 0);
    send_pose(mk(32'h00050000, 32'h00050000, 32'h00050000, 32'h00050000, 0, 0, 0, 16384), 0);
    send_pose(mk(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 0, 0, 0, 0), 0);
    send_pose(mk(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF), 0);
    send_pose(mk(32'h80000000, 0, 32'h7FFFFFFF, 32'h00020000, 0, 0, 16384, 0), 0);
    send_pose(mk(32'h80000000, 32'h00100000, 32'h00100000, 32'h00100000,
                 0, 0, -16'sd16384, 0), 0);
    send_pose(mk(0, 32'h80000000, 32'h00010000, 32'h00100000, 16384, 16384, 16384, 16384), 0);
    send_pose(mk(32'h00100000, 0, 32'h0000FFFF, 0, 0, 0, 0, 16384), 0);
    send_pose(mk(32'h00100000, 0, 32'h00010000, 0, 0, 0, 0, 16384), 0);
    send_pose(mk(32'h00100000, 0, 32'h0000B505, 32'h0000B505, 0, 0, 0, 16384), 0);
    send_pose(mk(32'hFFF00000, 32'hFFFFFFFF, 32'h00100000, 0,
                 -16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384), 0);
    send_pose(mk(32'hFFF00000, 0, 32'h00100000, 0, 0, 0, 11585, 11585), 0);
    send_pose(mk(32'hFFF00000, 0, 32'h00100000, 0, 0, 0, -16'sd11585, 11585), 0);
    drain();
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) send_pose(rand_pose(), 1);
    drain();
  endtask

  // receiver holds off while items keep coming so the pipeline fills
  task automatic test_backpressure();
    hold_off = 1;
    for (int i = 0; i < 80; i++) send_pose(rand_pose(), 0);
    drain();
  endtask

  task automatic test_settings();
    write_reg(phe_pkg::CFG_HOME_X, 32'h80000000);
    write_reg(phe_pkg::CFG_HOME_Y, 32'h7FFFFFFF);
    write_reg(phe_pkg::CFG_ARRIVE_RADIUS, 32'hFFFFFFFF);
    write_reg(phe_pkg::CFG_FORWARD_SPEED, 32'h7FFFFFFF);
    test_random(300);
    write_reg(phe_pkg::CFG_ARRIVE_RADIUS, 0);
    write_reg(phe_pkg::CFG_FORWARD_SPEED, 0);
    write_reg(phe_pkg::CFG_HOME_X, 32'h7FFFFFFF);
    write_reg(phe_pkg::CFG_HOME_Y, 32'h80000000);
    test_random(300);
    write_reg(phe_pkg::CFG_HOME_X, $urandom());
    write_reg(phe_pkg::CFG_HOME_Y, $urandom());
    write_reg(phe_pkg::CFG_ARRIVE_RADIUS, 32'h00200000);
    write_reg(phe_pkg::CFG_FORWARD_SPEED, $urandom());
    test_random(300);
    write_reg(phe_pkg::CFG_HOME_X, 0);
    write_reg(phe_pkg::CFG_HOME_Y, 0);
    write_reg(phe_pkg::CFG_ARRIVE_RADIUS, 32'h00018000);
    write_reg(phe_pkg::CFG_FORWARD_SPEED, 32'h00010000);
  endtask

  initial begin
    errors = 0; cycles = 0; hold_off = 0; stall_on = 0;
    home_x_m = 0; home_y_m = 0; radius_m = 65536; speed_m = 65536;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.target_x = '0; in_ch.target_y = '0;
    in_ch.follower_x = '0; in_ch.follower_y = '0;
    in_ch.follower_qx = '0; in_ch.follower_qy = '0;
    in_ch.follower_qz = '0; in_ch.follower_qw = '0;
    cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(200);
    stall_on = 1;
    test_random(400);
    test_backpressure();
    test_settings();
    test_random(400);

    if (errors == 0) begin
      $display("pursuit_heading_error_test: clean");
    end else begin
      $display("pursuit_heading_error_test: errors");
    end
    $finish;
  end
endmodule
